/* rtl/text_encoding_detector_defines.svh */
// ----------------------------------------------------------------------------
// Text encoding detector assertion macros
// Shared concurrent assertion forms for the detector RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_ENCODING_DETECTOR_DEFINES_SVH
`define TEXT_ENCODING_DETECTOR_DEFINES_SVH

// Checked on every rising edge of clk, suspended while reset is asserted.
`define TED_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("text_encoding_detector: assertion failed");

// Checked on every rising edge of clk, including reset cycles.
`define TED_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("text_encoding_detector: assertion failed");

`endif

/* rtl/tenc_pkg.sv */
// ----------------------------------------------------------------------------
// Text encoding detector package
// Result codes, byte constants and the scan summary type.
// ----------------------------------------------------------------------------
`default_nettype none

package tenc_pkg;

  // Result codes carried on the output channel.
  typedef enum logic [2:0] {
    ENC_UTF8     = 3'd0,
    ENC_UTF8_BOM = 3'd1,
    ENC_UTF16_LE = 3'd2,
    ENC_UTF16_BE = 3'd3,
    ENC_GBK      = 3'd4,
    ENC_SYSTEM   = 3'd5
  } enc_code_t;

  // Byte values and masks used by the structural checks.
  localparam logic [7:0] BYTE_EF   = 8'hEF;
  localparam logic [7:0] BYTE_BB   = 8'hBB;
  localparam logic [7:0] BYTE_BF   = 8'hBF;
  localparam logic [7:0] BYTE_FE   = 8'hFE;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] MASK_C0   = 8'hC0;
  localparam logic [7:0] MASK_E0   = 8'hE0;
  localparam logic [7:0] MASK_F0   = 8'hF0;
  localparam logic [7:0] MASK_F8   = 8'hF8;
  localparam logic [7:0] PAT_CONT  = 8'h80;
  localparam logic [7:0] PAT_LEAD2 = 8'hC0;
  localparam logic [7:0] PAT_LEAD3 = 8'hE0;
  localparam logic [7:0] PAT_LEAD4 = 8'hF0;
  localparam logic [7:0] GBK_LEAD_LO  = 8'h81;
  localparam logic [7:0] GBK_HI       = 8'hFE;
  localparam logic [7:0] GBK_TRAIL_LO = 8'h40;
  localparam logic [7:0] GBK_TRAIL_MD = 8'h7E;
  localparam logic [7:0] GBK_TRAIL_HI = 8'h80;

  // Running summary of a buffer, as it stands after the current byte.
  typedef struct packed {
    logic [1:0] byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [1:0] pend;
    logic       utf8_valid;
    logic       gbk_seen;
    logic       bom8_seen;
  } scan_sum_t;

  // True when the byte pair a, b fits the GBK double-byte pattern.
  function automatic logic gbk_pair(input logic [7:0] a, input logic [7:0] b);
    logic lead;
    logic trail;
    lead  = (a >= GBK_LEAD_LO) && (a <= GBK_HI);
    trail = ((b >= GBK_TRAIL_LO) && (b <= GBK_TRAIL_MD)) ||
            ((b >= GBK_TRAIL_HI) && (b <= GBK_HI));
    return lead && trail;
  endfunction

endpackage

`default_nettype wire

/* rtl/tenc_scan.sv */
// ----------------------------------------------------------------------------
// Text encoding detector byte scanner
// Holds the per-buffer state and folds each valid byte of a transaction into it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_encoding_detector_defines.svh"

module tenc_scan (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [7:0]          data_byte,
  input  wire logic                byte_valid,
  input  wire logic                last,
  output tenc_pkg::scan_sum_t      sum
);

  tenc_pkg::scan_sum_t cur_r;
  tenc_pkg::scan_sum_t cur_nxt;
  tenc_pkg::scan_sum_t clr;
  logic [7:0]          prev_r;
  logic [7:0]          prev_nxt;

  // Cleared buffer state.
  always_comb begin
    clr            = '0;
    clr.utf8_valid = 1'b1;
  end

  // Fold the incoming byte into the summary.
  always_comb begin
    sum = cur_r;
    if (byte_valid) begin
      unique case (cur_r.byte_count)
        2'd0: sum.first_byte = data_byte;
        2'd1: sum.second_byte = data_byte;
        2'd2: begin
          if ((cur_r.first_byte == tenc_pkg::BYTE_EF) &&
              (cur_r.second_byte == tenc_pkg::BYTE_BB) &&
              (data_byte == tenc_pkg::BYTE_BF)) begin
            sum.bom8_seen = 1'b1;
          end
        end
        default: ;
      endcase

      if ((cur_r.byte_count != 2'd0) && tenc_pkg::gbk_pair(prev_r, data_byte)) begin
        sum.gbk_seen = 1'b1;
      end

      // Structural UTF-8 lead and continuation checks.
      if (cur_r.utf8_valid) begin
        priority if (cur_r.pend != 2'd0) begin
          if ((data_byte & tenc_pkg::MASK_C0) != tenc_pkg::PAT_CONT) begin
            sum.utf8_valid = 1'b0;
          end else begin
            sum.pend = cur_r.pend - 2'd1;
          end
        end else if (data_byte < tenc_pkg::PAT_CONT) begin
          sum.pend = 2'd0;
        end else if ((data_byte & tenc_pkg::MASK_E0) == tenc_pkg::PAT_LEAD2) begin
          sum.pend = 2'd1;
        end else if ((data_byte & tenc_pkg::MASK_F0) == tenc_pkg::PAT_LEAD3) begin
          sum.pend = 2'd2;
        end else if ((data_byte & tenc_pkg::MASK_F8) == tenc_pkg::PAT_LEAD4) begin
          sum.pend = 2'd3;
        end else begin
          sum.utf8_valid = 1'b0;
        end
      end

      if (cur_r.byte_count != 2'd3) begin
        sum.byte_count = cur_r.byte_count + 2'd1;
      end
    end
  end

  // State advances on each transaction and clears after the transaction that carries last.
  always_comb begin
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    if (acc) begin
      if (last) begin
        cur_nxt  = clr;
        prev_nxt = '0;
      end else begin
        cur_nxt = sum;
        if (byte_valid) begin
          prev_nxt = data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= clr;
      prev_r <= '0;
    end else begin
      cur_r  <= cur_nxt;
      prev_r <= prev_nxt;
    end
  end

  // A buffer end always leaves a fresh state behind.
  `TED_ASSERT(a_clear_after_last,
    (acc && last) |=> (cur_r.byte_count == 2'd0 && cur_r.pend == 2'd0 &&
                       cur_r.utf8_valid && !cur_r.gbk_seen && !cur_r.bom8_seen))
  // Owed continuations only exist once a lead byte has been folded in.
  `TED_ASSERT(a_pend_needs_lead,
    (cur_r.pend != 2'd0) |-> (cur_r.byte_count != 2'd0))

endmodule

`default_nettype wire

/* rtl/tenc_classify.sv */
// ----------------------------------------------------------------------------
// Text encoding detector classifier
// Priority decision over the buffer summary.
// ----------------------------------------------------------------------------
`default_nettype none

module tenc_classify (
  input  wire tenc_pkg::scan_sum_t sum,
  output tenc_pkg::enc_code_t      code
);

  // Empty buffers read as UTF-8; then BOMs, then UTF-8 structure, then GBK pairs, else the system page.
  always_comb begin
    priority if (sum.byte_count == 2'd0) begin
      code = tenc_pkg::ENC_UTF8;
    end else if (sum.bom8_seen) begin
      code = tenc_pkg::ENC_UTF8_BOM;
    end else if ((sum.byte_count >= 2'd2) && (sum.first_byte == tenc_pkg::BYTE_FF) &&
                 (sum.second_byte == tenc_pkg::BYTE_FE)) begin
      code = tenc_pkg::ENC_UTF16_LE;
    end else if ((sum.byte_count >= 2'd2) && (sum.first_byte == tenc_pkg::BYTE_FE) &&
                 (sum.second_byte == tenc_pkg::BYTE_FF)) begin
      code = tenc_pkg::ENC_UTF16_BE;
    end else if (sum.utf8_valid && (sum.pend == 2'd0)) begin
      code = tenc_pkg::ENC_UTF8;
    end else if (sum.gbk_seen) begin
      code = tenc_pkg::ENC_GBK;
    end else begin
      code = tenc_pkg::ENC_SYSTEM;
    end
  end

endmodule

`default_nettype wire

/* rtl/text_encoding_detector.sv */
// ----------------------------------------------------------------------------
// Text encoding detector
// Classifies a streamed byte buffer as UTF-8, UTF-8 BOM, UTF-16, GBK or system.
// ----------------------------------------------------------------------------
// The result appears in out_valid in the cycle after the last transaction is taken.
// Throughput: one byte per cycle unless stalled; the scanner folds each byte into registered state.
// The result register frees itself in the cycle it is taken, so input stalls
// only while a finished result waits on out_ready.
// Reset: synchronous active-low rst_n clears the buffer state and the result.
`default_nettype none
`include "text_encoding_detector_defines.svh"

module text_encoding_detector (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_byte_valid,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_encoding_code
);

  logic                acc;
  tenc_pkg::scan_sum_t sum;
  tenc_pkg::enc_code_t code;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [2:0]          out_code_r;
  logic [2:0]          out_code_nxt;

  // Input side takes a transaction whenever the result slot is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  tenc_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_data_byte),
    .byte_valid (in_byte_valid),
    .last       (in_last),
    .sum        (sum)
  );

  tenc_classify u_classify (
    .sum  (sum),
    .code (code)
  );

  // Result register loads on the transaction that ends a buffer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    if (acc && in_last) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = code;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_encoding_code = out_code_r;

  // A result only ever follows a transaction that carried last.
  `TED_ASSERT(a_result_from_last,
    $rose(out_valid_r) |-> $past(in_valid && in_ready && in_last))
  // A held result blocks new input.
  `TED_ASSERT(a_stall_blocks_input, (out_valid_r && !out_ready) |-> !in_ready)
  // Result codes stay within the defined set.
  `TED_ASSERT(a_code_range,
    out_valid_r |-> (out_code_r != 3'd6 && out_code_r != 3'd7))
  // Reset leaves no result pending.
  `TED_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r)

endmodule

`default_nettype wire

/* verif/encoding_result_checker.sv */
// ----------------------------------------------------------------------------
// Encoding result checker
// Watches both channels of the text encoding detector. It keeps its own scan
// of every buffer that goes in and compares each result code that comes out
// with the oldest code still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoding_result_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_byte_valid,
  input  wire logic       in_last,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [2:0] out_encoding_code,
  output int              mismatch_count,
  output int              pending_results
);

  // Codes owed by the detector, oldest first.
  tenc_pkg::enc_code_t expected_codes[$];
  tenc_pkg::enc_code_t oldest_code;

  // Running scan of the buffer that is currently streaming in.
  logic [1:0] seen_count;
  logic [7:0] head_byte0;
  logic [7:0] head_byte1;
  logic [7:0] prior_byte;
  logic [1:0] owed_cont;
  logic       utf8_ok;
  logic       gbk_hit;
  logic       bom_hit;

  initial begin
    mismatch_count = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic clear_scan();
    seen_count = 2'd0;
    head_byte0 = 8'h00;
    head_byte1 = 8'h00;
    prior_byte = 8'h00;
    owed_cont  = 2'd0;
    utf8_ok    = 1'b1;
    gbk_hit    = 1'b0;
    bom_hit    = 1'b0;
  endtask

  // A lead byte in 81..FE followed by a trail byte in 40..7E or 80..FE.
  function automatic logic looks_like_gbk(input logic [7:0] a, input logic [7:0] b);
    logic lead_ok;
    logic trail_ok;
    lead_ok  = (a >= tenc_pkg::GBK_LEAD_LO) && (a <= tenc_pkg::GBK_HI);
    trail_ok = ((b >= tenc_pkg::GBK_TRAIL_LO) && (b <= tenc_pkg::GBK_TRAIL_MD)) ||
               ((b >= tenc_pkg::GBK_TRAIL_HI) && (b <= tenc_pkg::GBK_HI));
    return lead_ok && trail_ok;
  endfunction

  // Fold one byte into the running scan.
  task automatic scan_byte(input logic [7:0] b);
    if (seen_count == 2'd0) begin
      head_byte0 = b;
    end else if (seen_count == 2'd1) begin
      head_byte1 = b;
    end else if (seen_count == 2'd2) begin
      if (head_byte0 == tenc_pkg::BYTE_EF && head_byte1 == tenc_pkg::BYTE_BB &&
          b == tenc_pkg::BYTE_BF) begin
        bom_hit = 1'b1;
      end
    end

    if (seen_count != 2'd0 && looks_like_gbk(prior_byte, b)) begin
      gbk_hit = 1'b1;
    end

    // Structural UTF-8 check; once it fails it stays failed for the buffer.
    if (utf8_ok) begin
      if (owed_cont != 2'd0) begin
        if ((b & tenc_pkg::MASK_C0) != tenc_pkg::PAT_CONT) begin
          utf8_ok = 1'b0;
        end else begin
          owed_cont = owed_cont - 2'd1;
        end
      end else if (!b[7]) begin
        // Plain ASCII needs nothing further.
      end else if ((b & tenc_pkg::MASK_E0) == tenc_pkg::PAT_LEAD2) begin
        owed_cont = 2'd1;
      end else if ((b & tenc_pkg::MASK_F0) == tenc_pkg::PAT_LEAD3) begin
        owed_cont = 2'd2;
      end else if ((b & tenc_pkg::MASK_F8) == tenc_pkg::PAT_LEAD4) begin
        owed_cont = 2'd3;
      end else begin
        utf8_ok = 1'b0;
      end
    end

    prior_byte = b;
    if (seen_count != 2'd3) begin
      seen_count = seen_count + 2'd1;
    end
  endtask

  // Verdict for the buffer as scanned so far, in priority order.
  function automatic tenc_pkg::enc_code_t classify_buffer();
    if (seen_count == 2'd0) return tenc_pkg::ENC_UTF8;
    if (bom_hit) return tenc_pkg::ENC_UTF8_BOM;
    if (seen_count >= 2'd2) begin
      if (head_byte0 == tenc_pkg::BYTE_FF && head_byte1 == tenc_pkg::BYTE_FE) begin
        return tenc_pkg::ENC_UTF16_LE;
      end
      if (head_byte0 == tenc_pkg::BYTE_FE && head_byte1 == tenc_pkg::BYTE_FF) begin
        return tenc_pkg::ENC_UTF16_BE;
      end
    end
    if (utf8_ok && owed_cont == 2'd0) return tenc_pkg::ENC_UTF8;
    if (gbk_hit) return tenc_pkg::ENC_GBK;
    return tenc_pkg::ENC_SYSTEM;
  endfunction

  // Results are checked before the input side so that a result never meets
  // an expectation pushed at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      expected_codes.delete();
      pending_results <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("result code %0d with none expected",
                                    out_encoding_code));
        end else begin
          oldest_code = expected_codes.pop_front();
          if (out_encoding_code !== oldest_code) begin
            report_mismatch($sformatf("encoding_code %0d, expected %0d (%s)",
                                      out_encoding_code, oldest_code, oldest_code.name()));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_byte_valid) begin
          scan_byte(in_data_byte);
        end
        if (in_last) begin
          expected_codes.push_back(classify_buffer());
          clear_scan();
        end
      end
      pending_results <= expected_codes.size();
    end
  end

endmodule

/* verif/text_encoding_detector_test.sv */
// ----------------------------------------------------------------------------
// Text encoding detector testbench
// Streams directed and random byte buffers into the detector under several
// flow-control patterns, including a long output hold-off, while a checker
// beside the block predicts and compares every result code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_encoding_detector_test;

  localparam int RESET_CYCLES    = 7;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 10;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH_IDLE,
    PH_PRESSURE
  } phase_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_byte_valid;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_encoding_code;

  int     mismatch_count;
  int     pending_results;
  phase_t phase = PH_STEADY;
  int     send_idle_pct = 0;
  int     items_sent = 0;
  logic [7:0] text_bytes[$];

  always #1 clk = ~clk;

  text_encoding_detector uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_valid     (in_byte_valid),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_encoding_code (out_encoding_code)
  );

  encoding_result_checker result_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_valid     (in_byte_valid),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_encoding_code (out_encoding_code),
    .mismatch_count    (mismatch_count),
    .pending_results   (pending_results)
  );

  function automatic int stall_pct(input phase_t p);
    case (p)
      PH_RECEIVER_STALL: return 56;
      PH_BOTH_IDLE:      return 13;
      default:           return 0;
    endcase
  endfunction

  // Result side: random stalls per phase, plus one long hold-off when the
  // pressure phase begins so that the result register backs up the input.
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase == PH_PRESSURE && !held_off) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct(phase));
    end
  end

  // Offer one transaction and return at the edge that accepts it.
  task automatic send_item(input logic [7:0] b, input logic bv, input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_byte_valid <= bv;
    in_last       <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stream text_bytes as one buffer. With split_last the end is marked by a
  // separate transaction that carries no byte; an empty buffer always is.
  task automatic send_buffer(input bit split_last);
    int n;
    bit own_last;
    n = text_bytes.size();
    own_last = split_last || (n == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(text_bytes[i], 1'b1, (i == n - 1) && !own_last);
      items_sent++;
    end
    if (own_last) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      items_sent++;
    end
  endtask

  task automatic add_utf8_char();
    int len;
    len = $urandom_range(1, 4);
    case (len)
      1:       text_bytes.push_back(8'($urandom_range(0, 127)));
      2:       text_bytes.push_back(tenc_pkg::PAT_LEAD2 | 8'($urandom_range(0, 31)));
      3:       text_bytes.push_back(tenc_pkg::PAT_LEAD3 | 8'($urandom_range(0, 15)));
      default: text_bytes.push_back(tenc_pkg::PAT_LEAD4 | 8'($urandom_range(0, 7)));
    endcase
    for (int k = 1; k < len; k++) begin
      text_bytes.push_back(tenc_pkg::PAT_CONT | 8'($urandom_range(0, 63)));
    end
  endtask

  task automatic add_random_bytes(input int n);
    repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Build one random buffer: mostly well-formed text of some kind, the rest
  // broken sequences and raw noise.
  task automatic fill_buffer(input int max_chars);
    int kind;
    int n;
    text_bytes.delete();
    kind = $urandom_range(0, 99);
    n = $urandom_range(0, max_chars);
    if (kind < 40) begin
      repeat (n) add_utf8_char();
    end else if (kind < 52) begin
      // Byte order marks, whole or cut short, followed by anything.
      case ($urandom_range(0, 3))
        0: text_bytes = '{tenc_pkg::BYTE_EF, tenc_pkg::BYTE_BB, tenc_pkg::BYTE_BF};
        1: text_bytes = '{tenc_pkg::BYTE_FF, tenc_pkg::BYTE_FE};
        2: text_bytes = '{tenc_pkg::BYTE_FE, tenc_pkg::BYTE_FF};
        default: begin
          text_bytes.push_back(tenc_pkg::BYTE_EF);
          if ($urandom_range(0, 1)) text_bytes.push_back(tenc_pkg::BYTE_BB);
        end
      endcase
      if ($urandom_range(0, 1)) begin
        repeat (n) add_utf8_char();
      end else begin
        add_random_bytes(n);
      end
    end else if (kind < 65) begin
      // Double-byte text mixed with ASCII.
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) begin
          text_bytes.push_back(8'($urandom_range(0, 127)));
        end else begin
          text_bytes.push_back(8'($urandom_range(8'h81, 8'hFE)));
          if ($urandom_range(0, 1)) begin
            text_bytes.push_back(8'($urandom_range(8'h40, 8'h7E)));
          end else begin
            text_bytes.push_back(8'($urandom_range(8'h80, 8'hFE)));
          end
        end
      end
    end else if (kind < 80) begin
      // Valid UTF-8 with its tail cut off or one byte replaced.
      repeat (n + 1) add_utf8_char();
      if ($urandom_range(0, 1)) begin
        void'(text_bytes.pop_back());
      end else begin
        text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end else begin
      add_random_bytes(n);
    end
  endtask

  // Stop offering and wait until every owed result has been taken. The
  // first edge lets the checker's count catch up with the last acceptance.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic run_phase(input phase_t p, input int idle_pct, input int quota,
                           input int max_chars);
    int stop_at;
    wait_results_drained();
    phase <= p;
    send_idle_pct = idle_pct;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      fill_buffer(max_chars);
      send_buffer($urandom_range(0, 9) == 0);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_byte  <= 8'h00;
    in_byte_valid <= 1'b0;
    in_last       <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty buffer.
    text_bytes.delete();
    send_buffer(1'b1);
    // A non-byte transaction that is not last is ignored; one-byte buffers.
    send_item(8'h5A, 1'b0, 1'b0);
    text_bytes = '{8'hFF};
    send_buffer(1'b0);
    text_bytes = '{8'h80};
    send_buffer(1'b0);
    text_bytes = '{8'h7F};
    send_buffer(1'b0);
    // Byte order marks, and a UTF-8 mark cut short at two bytes.
    text_bytes = '{tenc_pkg::BYTE_EF, tenc_pkg::BYTE_BB, tenc_pkg::BYTE_BF};
    send_buffer(1'b0);
    text_bytes = '{tenc_pkg::BYTE_FF, tenc_pkg::BYTE_FE};
    send_buffer(1'b0);
    text_bytes = '{tenc_pkg::BYTE_FE, tenc_pkg::BYTE_FF};
    send_buffer(1'b0);
    text_bytes = '{tenc_pkg::BYTE_EF, tenc_pkg::BYTE_BB};
    send_buffer(1'b0);
    // End marked by a byteless transaction after bytes.
    text_bytes = '{8'h00};
    send_buffer(1'b1);
    // Two- and four-byte UTF-8, then a truncated three-byte sequence.
    text_bytes = '{8'hC3, 8'hA9};
    send_buffer(1'b0);
    text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_buffer(1'b0);
    text_bytes = '{8'hE2, 8'h82};
    send_buffer(1'b0);
    // Double-byte pair at the low corner, and a pair with a bad trail.
    text_bytes = '{8'h81, 8'h40};
    send_buffer(1'b0);
    text_bytes = '{8'hFE, 8'h7F};
    send_buffer(1'b0);

    run_phase(PH_STEADY, 0, 300, 10);
    run_phase(PH_SENDER_IDLE, 56, 350, 10);
    run_phase(PH_RECEIVER_STALL, 0, 350, 10);
    run_phase(PH_BOTH_IDLE, 13, 350, 10);
    run_phase(PH_PRESSURE, 0, 150, 2);
    run_phase(PH_STEADY, 0, 300, 10);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
